[hdl/gtc_pkg.sv]
// ----------------------------------------------------------------------------
// gtc_pkg
// Shared types, constants and helper functions of the gaze tracking
// controller: register indexes, configuration and state records.
// ----------------------------------------------------------------------------
package gtc_pkg;

	localparam int POS_W     = 16;
	localparam int OFF_W     = 10;
	localparam int FX_W      = 10;
	localparam int FY_W      = 9;
	localparam int GAIN_W    = 8;
	localparam int CNT_W     = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;
	// Working width for a position plus or minus offset times gain.
	localparam int WIDE_W    = 20;
	// Width for the raw centre offsets before saturation.
	localparam int RAW_W     = 12;

	localparam logic signed [RAW_W-1:0]  CENTRE_X   = RAW_W'(320);
	localparam logic signed [RAW_W-1:0]  CENTRE_Y   = RAW_W'(240);
	localparam logic signed [RAW_W-1:0]  OFFSET_MIN = -RAW_W'(512);
	localparam logic signed [RAW_W-1:0]  OFFSET_MAX = RAW_W'(511);
	localparam logic signed [WIDE_W-1:0] NECK_UP    = WIDE_W'(500);
	localparam logic signed [WIDE_W-1:0] NECK_DOWN  = -WIDE_W'(500);
	localparam logic [CNT_W-1:0]         LOST_MAX   = {CNT_W{1'b1}};

	localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(1);
	localparam logic [CNT_W-1:0]  LOST_RESET = CNT_W'(60);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_EYE_YAW_LIMITS    = 3'd0,
		REG_EYE_PITCH_LIMITS  = 3'd1,
		REG_NECK_LEFT_LIMITS  = 3'd2,
		REG_NECK_RIGHT_LIMITS = 3'd3,
		REG_EYE_CENTRES       = 3'd4,
		REG_NECK_CENTRE       = 3'd5,
		REG_EYE_GAIN          = 3'd6,
		REG_LOST_LIMIT        = 3'd7
	} reg_idx_t;

	typedef enum logic {
		OP_REPORT = 1'b0,
		OP_TICK   = 1'b1
	} op_t;

	typedef struct packed {
		logic signed [POS_W-1:0] yaw_min;
		logic signed [POS_W-1:0] yaw_max;
		logic signed [POS_W-1:0] pitch_min;
		logic signed [POS_W-1:0] pitch_max;
		logic signed [POS_W-1:0] left_min;
		logic signed [POS_W-1:0] left_max;
		logic signed [POS_W-1:0] right_min;
		logic signed [POS_W-1:0] right_max;
		logic signed [POS_W-1:0] pitch_centre;
		logic signed [POS_W-1:0] yaw_centre;
		logic signed [POS_W-1:0] neck_centre;
		logic [GAIN_W-1:0]       eye_gain;
		logic [CNT_W-1:0]        lost_limit;
	} cfg_t;

	typedef struct packed {
		logic                    face_present;
		logic signed [OFF_W-1:0] offset_x;
		logic signed [OFF_W-1:0] offset_y;
		logic [CNT_W-1:0]        lost_count;
		logic signed [POS_W-1:0] eye_pitch;
		logic signed [POS_W-1:0] eye_yaw;
		logic signed [POS_W-1:0] neck_left;
		logic signed [POS_W-1:0] neck_right;
	} state_t;

	typedef struct packed {
		logic                    op;
		logic                    face_valid;
		logic [FX_W-1:0]         face_x;
		logic [FY_W-1:0]         face_y;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] eye_pitch_target;
		logic signed [POS_W-1:0] eye_yaw_target;
		logic signed [POS_W-1:0] neck_left_target;
		logic signed [POS_W-1:0] neck_right_target;
		logic                    eye_cmd;
		logic                    neck_cmd;
		logic                    front_current_cmd;
	} result_t;

	// Raise to the minimum first, then lower to the maximum.
	function automatic logic signed [POS_W-1:0] clip_pos(
		input logic signed [WIDE_W-1:0] v,
		input logic signed [POS_W-1:0]  lo,
		input logic signed [POS_W-1:0]  hi
	);
		logic signed [WIDE_W-1:0] r;
		r = v;
		if (r < WIDE_W'(lo)) r = WIDE_W'(lo);
		if (r > WIDE_W'(hi)) r = WIDE_W'(hi);
		return r[POS_W-1:0];
	endfunction

	function automatic logic signed [OFF_W-1:0] sat_offset(
		input logic signed [RAW_W-1:0] v
	);
		logic signed [RAW_W-1:0] r;
		r = v;
		if (r < OFFSET_MIN) r = OFFSET_MIN;
		if (r > OFFSET_MAX) r = OFFSET_MAX;
		return r[OFF_W-1:0];
	endfunction

endpackage

[hdl/gtc_if.sv]
// ----------------------------------------------------------------------------
// gtc_if
// Valid/ready channels of the gaze tracking controller: input items,
// result items and configuration writes.
// ----------------------------------------------------------------------------
interface gtc_item_if import gtc_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            op;
	logic            face_valid;
	logic [FX_W-1:0] face_x;
	logic [FY_W-1:0] face_y;

	modport source (output valid, output op, output face_valid, output face_x,
		output face_y, input ready);
	modport sink (input valid, input op, input face_valid, input face_x,
		input face_y, output ready);
endinterface

interface gtc_result_if import gtc_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] eye_pitch_target;
	logic signed [POS_W-1:0] eye_yaw_target;
	logic signed [POS_W-1:0] neck_left_target;
	logic signed [POS_W-1:0] neck_right_target;
	logic                    eye_cmd;
	logic                    neck_cmd;
	logic                    front_current_cmd;

	modport source (output valid, output eye_pitch_target, output eye_yaw_target,
		output neck_left_target, output neck_right_target, output eye_cmd,
		output neck_cmd, output front_current_cmd, input ready);
	modport sink (input valid, input eye_pitch_target, input eye_yaw_target,
		input neck_left_target, input neck_right_target, input eye_cmd,
		input neck_cmd, input front_current_cmd, output ready);
endinterface

interface gtc_cfg_if import gtc_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DAT_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[hdl/gtc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// gtc_cfg_regs
// Configuration register file. Every transfer on the write channel updates
// one register; the channel never stalls.
// ----------------------------------------------------------------------------
module gtc_cfg_regs import gtc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	gtc_cfg_if.sink   cfg,
	output cfg_t      regs
);

	localparam cfg_t REGS_RESET = '{eye_gain: GAIN_RESET, lost_limit: LOST_RESET,
		default: '0};

	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= REGS_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_EYE_YAW_LIMITS: begin
					regs_q.yaw_min <= cfg.data[15:0];
					regs_q.yaw_max <= cfg.data[31:16];
				end
				REG_EYE_PITCH_LIMITS: begin
					regs_q.pitch_min <= cfg.data[15:0];
					regs_q.pitch_max <= cfg.data[31:16];
				end
				REG_NECK_LEFT_LIMITS: begin
					regs_q.left_min <= cfg.data[15:0];
					regs_q.left_max <= cfg.data[31:16];
				end
				REG_NECK_RIGHT_LIMITS: begin
					regs_q.right_min <= cfg.data[15:0];
					regs_q.right_max <= cfg.data[31:16];
				end
				REG_EYE_CENTRES: begin
					regs_q.pitch_centre <= cfg.data[15:0];
					regs_q.yaw_centre   <= cfg.data[31:16];
				end
				REG_NECK_CENTRE: begin
					regs_q.neck_centre <= cfg.data[POS_W-1:0];
				end
				REG_EYE_GAIN: begin
					regs_q.eye_gain <= cfg.data[GAIN_W-1:0];
				end
				REG_LOST_LIMIT: begin
					regs_q.lost_limit <= cfg.data[CNT_W-1:0];
				end
			endcase
		end
	end

endmodule

[hdl/gtc_step.sv]
// ----------------------------------------------------------------------------
// gtc_step
// Next-state and result logic for one item: offset capture on a report,
// eye stepping with clamping and neck nudges on a tick, and re-centring.
// ----------------------------------------------------------------------------
module gtc_step import gtc_pkg::*; (
	input  cfg_t    regs,
	input  state_t  cur,
	input  item_t   item,
	output state_t  nxt,
	output result_t res
);

	logic signed [RAW_W-1:0]        raw_x;
	logic signed [RAW_W-1:0]        raw_y;
	logic signed [GAIN_W:0]         gain_s;
	logic signed [OFF_W+GAIN_W:0]   prod_x;
	logic signed [OFF_W+GAIN_W:0]   prod_y;
	logic signed [WIDE_W-1:0]       yaw_raw;
	logic signed [WIDE_W-1:0]       pitch_raw;
	logic                           x_pos;
	logic                           y_pos;
	logic                           yaw_nudge;
	logic                           pitch_nudge;
	logic signed [WIDE_W-1:0]       yaw_dl;
	logic signed [WIDE_W-1:0]       yaw_dr;
	logic signed [WIDE_W-1:0]       pitch_d;
	logic signed [POS_W-1:0]        left_a;
	logic signed [POS_W-1:0]        right_a;
	logic signed [POS_W-1:0]        left_b;
	logic signed [POS_W-1:0]        right_b;
	logic                           recentre;

	assign raw_x = CENTRE_X - $signed({{(RAW_W-FX_W){1'b0}}, item.face_x});
	assign raw_y = $signed({{(RAW_W-FY_W){1'b0}}, item.face_y}) - CENTRE_Y;

	assign gain_s    = $signed({1'b0, regs.eye_gain});
	assign prod_x    = cur.offset_x * gain_s;
	assign prod_y    = cur.offset_y * gain_s;
	assign yaw_raw   = WIDE_W'(cur.eye_yaw) - WIDE_W'(prod_x);
	assign pitch_raw = WIDE_W'(cur.eye_pitch) - WIDE_W'(prod_y);

	assign x_pos = cur.offset_x > 0;
	assign y_pos = cur.offset_y > 0;

	// An eye that runs past the limit it is heading for pushes the neck.
	assign yaw_nudge   = x_pos ? (yaw_raw < WIDE_W'(regs.yaw_min))
		: (yaw_raw > WIDE_W'(regs.yaw_max));
	assign pitch_nudge = y_pos ? (pitch_raw < WIDE_W'(regs.pitch_min))
		: (pitch_raw > WIDE_W'(regs.pitch_max));

	assign yaw_dl  = x_pos ? NECK_UP : NECK_DOWN;
	assign yaw_dr  = x_pos ? NECK_DOWN : NECK_UP;
	assign pitch_d = y_pos ? NECK_DOWN : NECK_UP;

	// The yaw nudge is applied and clipped before the pitch nudge.
	assign left_a  = yaw_nudge ? clip_pos(WIDE_W'(cur.neck_left) + yaw_dl,
		regs.left_min, regs.left_max) : cur.neck_left;
	assign right_a = yaw_nudge ? clip_pos(WIDE_W'(cur.neck_right) + yaw_dr,
		regs.right_min, regs.right_max) : cur.neck_right;
	assign left_b  = pitch_nudge ? clip_pos(WIDE_W'(left_a) + pitch_d,
		regs.left_min, regs.left_max) : left_a;
	assign right_b = pitch_nudge ? clip_pos(WIDE_W'(right_a) + pitch_d,
		regs.right_min, regs.right_max) : right_a;

	assign recentre = !cur.face_present && (cur.lost_count > regs.lost_limit);

	always_comb begin
		nxt = cur;
		res = '0;
		if (item.op == OP_REPORT) begin
			if (item.face_valid) begin
				nxt.offset_x     = sat_offset(raw_x);
				nxt.offset_y     = sat_offset(raw_y);
				nxt.face_present = 1'b1;
				nxt.lost_count   = '0;
			end else begin
				nxt.face_present = 1'b0;
				if (cur.lost_count != LOST_MAX) nxt.lost_count = cur.lost_count + 1'b1;
			end
		end else if (cur.face_present) begin
			nxt.eye_yaw    = clip_pos(yaw_raw, regs.yaw_min, regs.yaw_max);
			nxt.eye_pitch  = clip_pos(pitch_raw, regs.pitch_min, regs.pitch_max);
			nxt.neck_left  = left_b;
			nxt.neck_right = right_b;
			res.eye_cmd           = 1'b1;
			res.front_current_cmd = 1'b1;
			res.neck_cmd          = yaw_nudge || pitch_nudge;
		end else if (recentre) begin
			nxt.eye_pitch  = clip_pos(WIDE_W'(regs.pitch_centre), regs.pitch_min,
				regs.pitch_max);
			nxt.eye_yaw    = clip_pos(WIDE_W'(regs.yaw_centre), regs.yaw_min,
				regs.yaw_max);
			nxt.neck_left  = clip_pos(WIDE_W'(regs.neck_centre), regs.left_min,
				regs.left_max);
			nxt.neck_right = clip_pos(WIDE_W'(regs.neck_centre), regs.right_min,
				regs.right_max);
			nxt.lost_count = '0;
			res.eye_cmd    = 1'b1;
			res.neck_cmd   = 1'b1;
		end
		if (res.eye_cmd) begin
			res.eye_pitch_target = nxt.eye_pitch;
			res.eye_yaw_target   = nxt.eye_yaw;
		end
		if (res.neck_cmd) begin
			res.neck_left_target  = nxt.neck_left;
			res.neck_right_target = nxt.neck_right;
		end
	end

endmodule

[hdl/gaze_tracking_controller_unit.sv]
// ----------------------------------------------------------------------------
// gaze_tracking_controller_unit
// Face-following eye and neck controller with a registered input stage,
// combinational update logic and a registered result.
// ----------------------------------------------------------------------------
// Usage:
//   item   : face reports (op = report) and control ticks (op = tick).
//   result : one transfer per tick carrying eye and neck targets and their
//            command flags; reports produce no result.
//   cfg    : register writes by index; always ready, one write per cycle.
// Timing:
//   An item is captured in the input register and evaluated there against the
//   controller state; a tick's result is loaded into the result register
//   when the tick leaves the input register, so a result transfer follows
//   its item through the input register and then the result register.
//   One item per cycle is accepted while no tick is held; the state update of
//   each item takes effect in time for the next one, so the update logic is
//   the single stage that sets the rate.
// Reset: registers return to their defaults, the head state to zero
//   positions with no face and a zero lost count, both channels empty.
// Stall: while a result waits, reports still pass; a tick is held in the
//   input register until the result register frees, and item.ready drops.
// ----------------------------------------------------------------------------
module gaze_tracking_controller_unit import gtc_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	gtc_item_if.sink      item,
	gtc_cfg_if.sink       cfg,
	gtc_result_if.source  result
);

	cfg_t    regs;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    item_v_s1;
	result_t res_nxt;
	result_t res_q;
	logic    res_v_q;
	logic    advance;

	gtc_cfg_regs u_cfg_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	gtc_step u_step (
		.regs (regs),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	assign advance    = item_v_s1 && ((item_s1.op == OP_REPORT) || !res_v_q || result.ready);
	assign item.ready = !item_v_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_s1 <= 1'b0;
		end else if (item.ready) begin
			item_v_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1.op         <= item.op;
			item_s1.face_valid <= item.face_valid;
			item_s1.face_x     <= item.face_x;
			item_s1.face_y     <= item.face_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// A new tick result may load in the same cycle the old one transfers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q <= 1'b0;
		end else begin
			if (result.ready) res_v_q <= 1'b0;
			if (advance && (item_s1.op == OP_TICK)) res_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && (item_s1.op == OP_TICK)) begin
			res_q <= res_nxt;
		end
	end

	assign result.valid             = res_v_q;
	assign result.eye_pitch_target  = res_q.eye_pitch_target;
	assign result.eye_yaw_target    = res_q.eye_yaw_target;
	assign result.neck_left_target  = res_q.neck_left_target;
	assign result.neck_right_target = res_q.neck_right_target;
	assign result.eye_cmd           = res_q.eye_cmd;
	assign result.neck_cmd          = res_q.neck_cmd;
	assign result.front_current_cmd = res_q.front_current_cmd;

endmodule

[verif/gtc_head_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gtc_head_checker
// Watches the item, configuration and result channels of the gaze tracking
// controller, keeps its own copy of the head state and settings, predicts
// the targets of every tick and compares them with the results in order.
// ----------------------------------------------------------------------------
module gtc_head_checker import gtc_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	gtc_item_if    item,
	gtc_cfg_if     cfg,
	gtc_result_if  result,
	output int     err_count,
	output int     outstanding
);

	cfg_t    settings;
	state_t  head;
	result_t target_queue[$];

	function automatic int limit_to(input int v, input logic signed [POS_W-1:0] lo,
		input logic signed [POS_W-1:0] hi);
		if (v < lo) v = lo;
		if (v > hi) v = hi;
		return v;
	endfunction

	function automatic void shift_neck(input int dl, input int dr);
		head.neck_left  = POS_W'(limit_to(int'(head.neck_left) + dl, settings.left_min,
			settings.left_max));
		head.neck_right = POS_W'(limit_to(int'(head.neck_right) + dr, settings.right_min,
			settings.right_max));
	endfunction

	// Applies one item to the head state; returns 1 when it yields a result.
	function automatic bit head_update(input item_t it, output result_t r);
		int  ox, oy, gain, yaw, pitch;
		bit  eye_on, neck_on, front_on;
		r        = '0;
		eye_on   = 1'b0;
		neck_on  = 1'b0;
		front_on = 1'b0;
		if (op_t'(it.op) == OP_REPORT) begin
			if (it.face_valid) begin
				ox = limit_to(int'(CENTRE_X) - int'(it.face_x), int'(OFFSET_MIN),
					int'(OFFSET_MAX));
				oy = limit_to(int'(it.face_y) - int'(CENTRE_Y), int'(OFFSET_MIN),
					int'(OFFSET_MAX));
				head.offset_x     = ox[OFF_W-1:0];
				head.offset_y     = oy[OFF_W-1:0];
				head.face_present = 1'b1;
				head.lost_count   = '0;
			end else begin
				head.face_present = 1'b0;
				if (head.lost_count != LOST_MAX)
					head.lost_count = head.lost_count + 1'b1;
			end
			return 1'b0;
		end
		if (head.face_present) begin
			ox    = int'(head.offset_x);
			oy    = int'(head.offset_y);
			gain  = int'(settings.eye_gain);
			yaw   = int'(head.eye_yaw) - ox * gain;
			pitch = int'(head.eye_pitch) - oy * gain;
			// An eye pinned at a limit hands the rest of the motion to the neck.
			if (ox > 0) begin
				if (yaw < settings.yaw_min) begin
					yaw = settings.yaw_min;
					shift_neck(int'(NECK_UP), int'(NECK_DOWN));
					neck_on = 1'b1;
				end
			end else if (yaw > settings.yaw_max) begin
				yaw = settings.yaw_max;
				shift_neck(int'(NECK_DOWN), int'(NECK_UP));
				neck_on = 1'b1;
			end
			if (oy > 0) begin
				if (pitch < settings.pitch_min) begin
					pitch = settings.pitch_min;
					shift_neck(int'(NECK_DOWN), int'(NECK_DOWN));
					neck_on = 1'b1;
				end
			end else if (pitch > settings.pitch_max) begin
				pitch = settings.pitch_max;
				shift_neck(int'(NECK_UP), int'(NECK_UP));
				neck_on = 1'b1;
			end
			head.eye_pitch = POS_W'(limit_to(pitch, settings.pitch_min, settings.pitch_max));
			head.eye_yaw   = POS_W'(limit_to(yaw, settings.yaw_min, settings.yaw_max));
			eye_on   = 1'b1;
			front_on = 1'b1;
		end else if (head.lost_count > settings.lost_limit) begin
			head.eye_pitch  = POS_W'(limit_to(settings.pitch_centre, settings.pitch_min,
				settings.pitch_max));
			head.eye_yaw    = POS_W'(limit_to(settings.yaw_centre, settings.yaw_min,
				settings.yaw_max));
			head.neck_left  = POS_W'(limit_to(settings.neck_centre, settings.left_min,
				settings.left_max));
			head.neck_right = POS_W'(limit_to(settings.neck_centre, settings.right_min,
				settings.right_max));
			head.lost_count = '0;
			eye_on  = 1'b1;
			neck_on = 1'b1;
		end
		if (eye_on) begin
			r.eye_pitch_target = head.eye_pitch;
			r.eye_yaw_target   = head.eye_yaw;
		end
		if (neck_on) begin
			r.neck_left_target  = head.neck_left;
			r.neck_right_target = head.neck_right;
		end
		r.eye_cmd           = eye_on;
		r.neck_cmd          = neck_on;
		r.front_current_cmd = front_on;
		return 1'b1;
	endfunction

	task automatic check_field(input string name, input logic [POS_W-1:0] want,
		input logic [POS_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		item_t   it;
		result_t want, got;
		if (!arst_n) begin
			settings            = '0;
			settings.eye_gain   = GAIN_RESET;
			settings.lost_limit = LOST_RESET;
			head                = '0;
			target_queue.delete();
			err_count   = 0;
			outstanding = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (reg_idx_t'(cfg.index))
					REG_EYE_YAW_LIMITS: begin
						settings.yaw_min = cfg.data[15:0];
						settings.yaw_max = cfg.data[31:16];
					end
					REG_EYE_PITCH_LIMITS: begin
						settings.pitch_min = cfg.data[15:0];
						settings.pitch_max = cfg.data[31:16];
					end
					REG_NECK_LEFT_LIMITS: begin
						settings.left_min = cfg.data[15:0];
						settings.left_max = cfg.data[31:16];
					end
					REG_NECK_RIGHT_LIMITS: begin
						settings.right_min = cfg.data[15:0];
						settings.right_max = cfg.data[31:16];
					end
					REG_EYE_CENTRES: begin
						settings.pitch_centre = cfg.data[15:0];
						settings.yaw_centre   = cfg.data[31:16];
					end
					REG_NECK_CENTRE: settings.neck_centre = cfg.data[15:0];
					REG_EYE_GAIN:    settings.eye_gain    = cfg.data[GAIN_W-1:0];
					REG_LOST_LIMIT:  settings.lost_limit  = cfg.data[CNT_W-1:0];
				endcase
			end
			if (item.valid && item.ready) begin
				it.op         = item.op;
				it.face_valid = item.face_valid;
				it.face_x     = item.face_x;
				it.face_y     = item.face_y;
				if (head_update(it, want))
					target_queue.insert(target_queue.size(), want);
			end
			if (result.valid && result.ready) begin
				got.eye_pitch_target  = result.eye_pitch_target;
				got.eye_yaw_target    = result.eye_yaw_target;
				got.neck_left_target  = result.neck_left_target;
				got.neck_right_target = result.neck_right_target;
				got.eye_cmd           = result.eye_cmd;
				got.neck_cmd          = result.neck_cmd;
				got.front_current_cmd = result.front_current_cmd;
				if (target_queue.size() == 0) begin
					$error("result transfer with no tick waiting for it");
					err_count++;
				end else begin
					want = target_queue.pop_front();
					check_field("eye_pitch_target", want.eye_pitch_target,
						got.eye_pitch_target);
					check_field("eye_yaw_target", want.eye_yaw_target, got.eye_yaw_target);
					check_field("neck_left_target", want.neck_left_target,
						got.neck_left_target);
					check_field("neck_right_target", want.neck_right_target,
						got.neck_right_target);
					check_field("eye_cmd", want.eye_cmd, got.eye_cmd);
					check_field("neck_cmd", want.neck_cmd, got.neck_cmd);
					check_field("front_current_cmd", want.front_current_cmd,
						got.front_current_cmd);
				end
			end
			outstanding = target_queue.size();
		end
	end

endmodule

[verif/tb_gaze_tracking_controller_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaze_tracking_controller_unit
// Drives face reports, ticks and register writes into the gaze tracking
// controller under random idling on both sides, with directed cases, random
// settings and runs of lost reports; the checker judges every result.
// ----------------------------------------------------------------------------
module tb_gaze_tracking_controller_unit;
	import gtc_pkg::*;

	logic clk;
	logic arst_n;
	bit   calm = 1'b0;
	int   lost_allow;
	int   err_count;
	int   outstanding;

	gtc_item_if   item_ch ();
	gtc_cfg_if    cfg_ch ();
	gtc_result_if result_ch ();

	gaze_tracking_controller_unit u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.cfg    (cfg_ch),
		.result (result_ch)
	);

	gtc_head_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.cfg         (cfg_ch),
		.result      (result_ch),
		.err_count   (err_count),
		.outstanding (outstanding)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		result_ch.ready <= calm || ($urandom_range(99) >= 22);
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	function automatic logic [31:0] span(input int lo, input int hi);
		return {16'(hi), 16'(lo)};
	endfunction

	task automatic send(input op_t op, input logic fv, input logic [FX_W-1:0] x,
		input logic [FY_W-1:0] y);
		while (!calm && $urandom_range(99) < 22) begin
			item_ch.valid <= 1'b0;
			@(negedge clk);
		end
		item_ch.valid      <= 1'b1;
		item_ch.op         <= op;
		item_ch.face_valid <= fv;
		item_ch.face_x     <= x;
		item_ch.face_y     <= y;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Holds the sender back until every tick has been answered.
	task automatic drain();
		item_ch.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	// Reports leave no result behind, so give the pipeline time to empty too.
	task automatic settle();
		drain();
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic configure(input logic [31:0] yaw_lim, input logic [31:0] pitch_lim,
		input logic [31:0] left_lim, input logic [31:0] right_lim,
		input logic [31:0] centres, input logic [15:0] neck_mid,
		input logic [7:0] gain, input logic [15:0] lost);
		write_reg(REG_EYE_YAW_LIMITS, yaw_lim);
		write_reg(REG_EYE_PITCH_LIMITS, pitch_lim);
		write_reg(REG_NECK_LEFT_LIMITS, left_lim);
		write_reg(REG_NECK_RIGHT_LIMITS, right_lim);
		write_reg(REG_EYE_CENTRES, centres);
		// Upper bits of the narrow registers carry noise that must be dropped.
		write_reg(REG_NECK_CENTRE, {16'($urandom), neck_mid});
		write_reg(REG_EYE_GAIN, {24'($urandom), gain});
		write_reg(REG_LOST_LIMIT, {16'($urandom), lost});
		cfg_ch.valid <= 1'b0;
		lost_allow = lost;
	endtask

	task automatic random_setup(input bit wild);
		if (wild)
			configure($urandom, $urandom, $urandom, $urandom, $urandom, 16'($urandom),
				8'($urandom), 16'($urandom_range(0, 8)));
		else
			configure(span(-int'($urandom_range(0, 6000)), $urandom_range(0, 6000)),
				span(-int'($urandom_range(0, 6000)), $urandom_range(0, 6000)),
				span(-int'($urandom_range(0, 4000)), $urandom_range(0, 4000)),
				span(-int'($urandom_range(0, 4000)), $urandom_range(0, 4000)),
				span($urandom_range(0, 400) - 200, $urandom_range(0, 400) - 200),
				16'($urandom_range(0, 600) - 300), 8'($urandom_range(0, 12)),
				16'($urandom_range(0, 6)));
	endtask

	// Mostly a face report followed by a few ticks, or a run of lost reports
	// closed by a tick; the rest is single random items.
	task automatic run_traffic(input int count);
		int sent, n, pick;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 55) begin
				send(OP_REPORT, 1'b1, $urandom_range(0, 639), $urandom_range(0, 479));
				n = $urandom_range(1, 3);
				repeat (n) send(OP_TICK, 1'($urandom), $urandom_range(0, 639),
					$urandom_range(0, 479));
				sent += n + 1;
			end else if (pick < 80) begin
				n = $urandom_range(0, lost_allow + 2);
				repeat (n) send(OP_REPORT, 1'b0, $urandom_range(0, 639),
					$urandom_range(0, 479));
				send(OP_TICK, 1'($urandom), $urandom_range(0, 639), $urandom_range(0, 479));
				sent += n + 1;
			end else begin
				send(op_t'($urandom_range(0, 1)), 1'($urandom), $urandom_range(0, 639),
					$urandom_range(0, 479));
				sent++;
			end
			if ($urandom_range(0, 39) == 0)
				drain();
		end
	endtask

	initial begin : stimulus
		arst_n             = 1'b0;
		item_ch.valid      = 1'b0;
		item_ch.op         = OP_REPORT;
		item_ch.face_valid = 1'b0;
		item_ch.face_x     = '0;
		item_ch.face_y     = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = REG_EYE_YAW_LIMITS;
		cfg_ch.data        = '0;
		lost_allow         = int'(LOST_RESET);
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset settings: all limits at zero, so every move is pinned.
		send(OP_TICK, 1'b0, '0, '0);
		send(OP_REPORT, 1'b1, 10'd320, 9'd240);
		send(OP_TICK, 1'b0, '0, '0);

		settle();
		configure(span(-1000, 1000), span(-800, 800), span(-1200, 1200),
			span(-1200, 1200), span(100, -200), 16'd50, 8'd3, 16'd2);
		// Face in a far corner walks both eyes into their limits and the neck.
		send(OP_REPORT, 1'b1, 10'd0, 9'd0);
		repeat (3) send(OP_TICK, 1'b0, '0, '0);
		send(OP_REPORT, 1'b1, 10'd639, 9'd479);
		repeat (2) send(OP_TICK, 1'b1, 10'd639, 9'd479);
		send(OP_REPORT, 1'b1, 10'd320, 9'd240);
		send(OP_TICK, 1'b0, '0, '0);
		// One lost report beyond the limit re-centres; at the limit stays idle.
		repeat (3) send(OP_REPORT, 1'b0, 10'd639, 9'd479);
		send(OP_TICK, 1'b0, '0, '0);
		repeat (2) send(OP_REPORT, 1'b0, 10'd0, 9'd0);
		send(OP_TICK, 1'b0, '0, '0);
		send(OP_REPORT, 1'b1, 10'd639, 9'd0);
		send(OP_TICK, 1'b0, '0, '0);
		send(OP_REPORT, 1'b1, 10'd0, 9'd479);
		send(OP_TICK, 1'b0, '0, '0);

		settle();
		configure(span(-32768, 32767), span(1000, -1000), span(-32768, 32767),
			span(300, -300), span(-32768, 32767), 16'h8000, 8'd255, 16'd0);
		run_traffic(100);

		settle();
		configure(span(32767, -32768), span(-32768, 32767), span(-500, 500),
			span(-32768, 32767), span(32767, -32768), 16'h7fff, 8'd0, 16'd1);
		run_traffic(60);

		settle();
		random_setup(1'b0);
		run_traffic(120);

		settle();
		calm = 1'b1;
		random_setup(1'b1);
		run_traffic(120);
		calm = 1'b0;

		settle();
		random_setup(1'b0);
		run_traffic(100);

		drain();
		repeat (8) @(negedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[gaze_tracking_controller_unit.f]
hdl/gtc_pkg.sv
hdl/gtc_if.sv
hdl/gtc_cfg_regs.sv
hdl/gtc_step.sv
hdl/gaze_tracking_controller_unit.sv
verif/gtc_head_checker.sv
verif/tb_gaze_tracking_controller_unit.sv
